>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/i2c_seq_pkg.sv
// Types and constants of the I2C register transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2c_seq_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 16;
  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [1:0] {
    ACT_BEGIN_WRITE = 2'd0,
    ACT_BEGIN_READ  = 2'd1,
    ACT_EVENT       = 2'd2,
    ACT_POLL        = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_WRITE = 3'b010,
    MODE_READ  = 3'b100
  } mode_e;

  localparam logic [ByteW-1:0] ST_START       = 8'h08;
  localparam logic [ByteW-1:0] ST_RESTART     = 8'h10;
  localparam logic [ByteW-1:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [ByteW-1:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [ByteW-1:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [ByteW-1:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [ByteW-1:0] ST_ARB_LOST    = 8'h38;
  localparam logic [ByteW-1:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [ByteW-1:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [ByteW-1:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [ByteW-1:0] ST_DATA_R_NACK = 8'h58;
  localparam logic [ByteW-1:0] READ_BIT       = 8'h01;

  localparam logic [CfgIdxW-1:0] CFG_SLAVE_ADDRESS = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_LIMIT = 8'd1;

  localparam logic [ByteW-1:0] SLAVE_ADDRESS_RST = 8'd120;
  localparam logic [ByteW-1:0] TIMEOUT_LIMIT_RST = 8'd100;

  typedef struct packed {
    action_e            action;
    logic [ByteW-1:0]   reg_addr;
    logic [LengthW-1:0] length;
    logic [ByteW-1:0]   status;
    logic [ByteW-1:0]   rx_byte;
    logic [ByteW-1:0]   tx_byte;
  } req_t;

  typedef struct packed {
    logic             start_set;
    logic             start_clear;
    logic             stop_set;
    logic             ack_on;
    logic             ack_off;
    logic             write_strobe;
    logic [ByteW-1:0] write_byte;
    logic             read_strobe;
    logic [ByteW-1:0] read_byte;
    logic             finished;
    logic             failed;
    logic             irq_clear;
  } rsp_t;

  typedef struct packed {
    logic               wr;
    logic [CfgIdxW-1:0] index;
    logic [ByteW-1:0]   data;
  } cfg_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/i2c_seq_if.sv
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface i2c_seq_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic [i2c_seq_pkg::ByteW-1:0]      reg_addr;
  logic [i2c_seq_pkg::LengthW-1:0]    length;
  logic [i2c_seq_pkg::ByteW-1:0]      status;
  logic [i2c_seq_pkg::ByteW-1:0]      rx_byte;
  logic [i2c_seq_pkg::ByteW-1:0]      tx_byte;

  modport source (output valid, action, reg_addr, length, status, rx_byte, tx_byte,
                  input ready);
  modport sink (input valid, action, reg_addr, length, status, rx_byte, tx_byte,
                output ready);
endinterface

interface i2c_seq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          start_set;
  logic                          start_clear;
  logic                          stop_set;
  logic                          ack_on;
  logic                          ack_off;
  logic                          write_strobe;
  logic [i2c_seq_pkg::ByteW-1:0] write_byte;
  logic                          read_strobe;
  logic [i2c_seq_pkg::ByteW-1:0] read_byte;
  logic                          finished;
  logic                          failed;
  logic                          irq_clear;

  modport source (output valid, start_set, start_clear, stop_set, ack_on, ack_off,
                  write_strobe, write_byte, read_strobe, read_byte, finished, failed,
                  irq_clear, input ready);
  modport sink (input valid, start_set, start_clear, stop_set, ack_on, ack_off,
                write_strobe, write_byte, read_strobe, read_byte, finished, failed,
                irq_clear, output ready);
endinterface

interface i2c_seq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [i2c_seq_pkg::CfgIdxW-1:0] index;
  logic [i2c_seq_pkg::ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/i2c_seq_in_reg.sv
// Input register stage holding one request.
`timescale 1ns / 1ps
`default_nettype none
module i2c_seq_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire i2c_seq_pkg::req_t req_i,
  output logic                   ready_o,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output i2c_seq_pkg::req_t      req_o
);

  logic              valid_q;
  i2c_seq_pkg::req_t req_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2c_seq_core.sv
// Transfer state, configuration registers and per-request decision logic.
`timescale 1ns / 1ps
`default_nettype none
module i2c_seq_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire i2c_seq_pkg::cfg_wr_t cfg_i,
  input  wire logic                 advance_i,
  input  wire i2c_seq_pkg::req_t    req_i,
  output i2c_seq_pkg::rsp_t         rsp_o
);

  localparam int unsigned ByteW = i2c_seq_pkg::ByteW;

  logic [ByteW-1:0]      slave_addr_q;
  logic [ByteW-1:0]      timeout_q;
  i2c_seq_pkg::mode_e    mode_q, mode_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] tgt_q, tgt_d;
  logic [ByteW-1:0]      raddr_q, raddr_d;
  logic [ByteW-1:0]      poll_q, poll_d;

  logic [COUNT_BITS-1:0] len_trunc;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS:0]   cnt_inc_plus;
  logic [ByteW:0]        poll_next;
  i2c_seq_pkg::rsp_t     rsp;

  assign len_trunc    = req_i.length[COUNT_BITS-1:0];
  assign cnt_inc      = cnt_q + COUNT_BITS'(1);
  assign cnt_inc_plus = {1'b0, cnt_inc} + (COUNT_BITS+1)'(1);
  assign poll_next    = {1'b0, poll_q} + (ByteW+1)'(1);

  always_comb begin
    rsp     = '0;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    tgt_d   = tgt_q;
    raddr_d = raddr_q;
    poll_d  = poll_q;
    case (req_i.action)
      i2c_seq_pkg::ACT_BEGIN_WRITE, i2c_seq_pkg::ACT_BEGIN_READ: begin
        if (mode_q == i2c_seq_pkg::MODE_IDLE) begin
          if (req_i.action == i2c_seq_pkg::ACT_BEGIN_READ && len_trunc == '0) begin
            rsp.failed = 1'b1;
          end else begin
            mode_d        = (req_i.action == i2c_seq_pkg::ACT_BEGIN_WRITE) ?
                            i2c_seq_pkg::MODE_WRITE : i2c_seq_pkg::MODE_READ;
            cnt_d         = '0;
            tgt_d         = len_trunc;
            raddr_d       = req_i.reg_addr;
            poll_d        = '0;
            rsp.start_set = 1'b1;
          end
        end
      end
      i2c_seq_pkg::ACT_EVENT: begin
        if (mode_q != i2c_seq_pkg::MODE_IDLE) begin
          poll_d        = '0;
          rsp.irq_clear = 1'b1;
          if (mode_q == i2c_seq_pkg::MODE_WRITE) begin
            case (req_i.status)
              i2c_seq_pkg::ST_START: begin
                rsp.start_clear  = 1'b1;
                rsp.write_strobe = 1'b1;
                rsp.write_byte   = slave_addr_q;
              end
              i2c_seq_pkg::ST_SLA_W_ACK: begin
                rsp.write_strobe = 1'b1;
                rsp.write_byte   = raddr_q;
              end
              i2c_seq_pkg::ST_DATA_W_ACK: begin
                if (cnt_q >= tgt_q) begin
                  rsp.stop_set = 1'b1;
                  rsp.finished = 1'b1;
                  mode_d       = i2c_seq_pkg::MODE_IDLE;
                end else begin
                  rsp.write_strobe = 1'b1;
                  rsp.write_byte   = req_i.tx_byte;
                  cnt_d            = cnt_inc;
                end
              end
              i2c_seq_pkg::ST_SLA_W_NACK, i2c_seq_pkg::ST_DATA_W_NACK,
              i2c_seq_pkg::ST_ARB_LOST: begin
                rsp.stop_set = 1'b1;
                rsp.failed   = 1'b1;
                mode_d       = i2c_seq_pkg::MODE_IDLE;
              end
              default: ;
            endcase
          end else begin
            case (req_i.status)
              i2c_seq_pkg::ST_START: begin
                rsp.start_clear  = 1'b1;
                rsp.write_strobe = 1'b1;
                rsp.write_byte   = slave_addr_q;
              end
              i2c_seq_pkg::ST_SLA_W_ACK: begin
                rsp.write_strobe = 1'b1;
                rsp.write_byte   = raddr_q;
              end
              i2c_seq_pkg::ST_DATA_W_ACK: begin
                rsp.start_set = 1'b1;
              end
              i2c_seq_pkg::ST_RESTART: begin
                rsp.start_clear  = 1'b1;
                rsp.write_strobe = 1'b1;
                rsp.write_byte   = slave_addr_q | i2c_seq_pkg::READ_BIT;
              end
              i2c_seq_pkg::ST_SLA_R_ACK: begin
                if (tgt_q > COUNT_BITS'(1)) begin
                  rsp.ack_on = 1'b1;
                end else begin
                  rsp.ack_off = 1'b1;
                end
              end
              i2c_seq_pkg::ST_DATA_R_ACK: begin
                rsp.read_strobe = 1'b1;
                rsp.read_byte   = req_i.rx_byte;
                cnt_d           = cnt_inc;
                if (cnt_inc >= tgt_q) begin
                  rsp.stop_set = 1'b1;
                  rsp.finished = 1'b1;
                  mode_d       = i2c_seq_pkg::MODE_IDLE;
                end else if (cnt_inc_plus == {1'b0, tgt_q}) begin
                  rsp.ack_off = 1'b1;
                end
              end
              i2c_seq_pkg::ST_DATA_R_NACK: begin
                rsp.read_strobe = 1'b1;
                rsp.read_byte   = req_i.rx_byte;
                cnt_d           = cnt_inc;
                rsp.stop_set    = 1'b1;
                rsp.finished    = (cnt_inc == tgt_q);
                rsp.failed      = (cnt_inc != tgt_q);
                mode_d          = i2c_seq_pkg::MODE_IDLE;
              end
              i2c_seq_pkg::ST_SLA_R_NACK: begin
                rsp.stop_set = 1'b1;
                rsp.failed   = 1'b1;
                mode_d       = i2c_seq_pkg::MODE_IDLE;
              end
              default: begin
                rsp.stop_set = 1'b1;
                rsp.failed   = 1'b1;
                mode_d       = i2c_seq_pkg::MODE_IDLE;
              end
            endcase
          end
        end
      end
      i2c_seq_pkg::ACT_POLL: begin
        if (mode_q != i2c_seq_pkg::MODE_IDLE) begin
          if (poll_next > {1'b0, timeout_q}) begin
            rsp.stop_set  = 1'b1;
            rsp.irq_clear = 1'b1;
            rsp.failed    = 1'b1;
            mode_d        = i2c_seq_pkg::MODE_IDLE;
            poll_d        = '0;
          end else begin
            poll_d = poll_next[ByteW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign rsp_o = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= i2c_seq_pkg::SLAVE_ADDRESS_RST;
      timeout_q    <= i2c_seq_pkg::TIMEOUT_LIMIT_RST;
    end else if (cfg_i.wr) begin
      if (cfg_i.index == i2c_seq_pkg::CFG_SLAVE_ADDRESS) begin
        slave_addr_q <= cfg_i.data;
      end else if (cfg_i.index == i2c_seq_pkg::CFG_TIMEOUT_LIMIT) begin
        timeout_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= i2c_seq_pkg::MODE_IDLE;
      cnt_q   <= '0;
      tgt_q   <= '0;
      raddr_q <= '0;
      poll_q  <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      raddr_q <= raddr_d;
      poll_q  <= poll_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2c_seq_out_reg.sv
// Result register holding one engine command word until taken.
`timescale 1ns / 1ps
`default_nettype none
module i2c_seq_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire i2c_seq_pkg::rsp_t rsp_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output i2c_seq_pkg::rsp_t      rsp_o
);

  logic              valid_q;
  i2c_seq_pkg::rsp_t rsp_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      rsp_q <= rsp_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2c_master_register_transfer_sequencer.sv
// Top level of the I2C master register transfer sequencer.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    action, reg_addr, length, status, rx_byte, tx_byte
//   rsp_o    out  valid/ready    engine commands, read_byte, finished, failed
//   cfg_i    in   valid/ready    index, data (0 slave address, 1 timeout limit)
//
// One request per cycle sustained while results are taken; each request yields exactly one result.
// A request is held in the input register, then passes the decision logic into the result register.
// Configuration writes are always ready and take effect on the next cycle.
// Reset sets the valid flags, transfer state and configuration registers at once; no clearing pass.
// A stalled result holds the result register; the input register then takes at most one more request.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_register_transfer_sequencer #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  i2c_seq_req_if.sink   req_i,
  i2c_seq_rsp_if.source rsp_o,
  i2c_seq_cfg_if.sink   cfg_i
);

  i2c_seq_pkg::req_t    req_in;
  i2c_seq_pkg::req_t    req_st;
  i2c_seq_pkg::rsp_t    rsp_next;
  i2c_seq_pkg::rsp_t    rsp_st;
  i2c_seq_pkg::cfg_wr_t cfg_wr;
  logic                 st_valid;
  logic                 out_free;
  logic                 advance;
  logic                 in_ready;
  logic                 out_valid;

  assign req_in.action   = i2c_seq_pkg::action_e'(req_i.action);
  assign req_in.reg_addr = req_i.reg_addr;
  assign req_in.length   = req_i.length;
  assign req_in.status   = req_i.status;
  assign req_in.rx_byte  = req_i.rx_byte;
  assign req_in.tx_byte  = req_i.tx_byte;
  assign req_i.ready     = in_ready;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.wr    = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  assign advance = st_valid && out_free;

  i2c_seq_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_i.valid),
    .req_i     (req_in),
    .ready_o   (in_ready),
    .advance_i (advance),
    .valid_o   (st_valid),
    .req_o     (req_st)
  );

  i2c_seq_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .advance_i (advance),
    .req_i     (req_st),
    .rsp_o     (rsp_next)
  );

  i2c_seq_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .rsp_i   (rsp_next),
    .free_o  (out_free),
    .valid_o (out_valid),
    .ready_i (rsp_o.ready),
    .rsp_o   (rsp_st)
  );

  assign rsp_o.valid        = out_valid;
  assign rsp_o.start_set    = rsp_st.start_set;
  assign rsp_o.start_clear  = rsp_st.start_clear;
  assign rsp_o.stop_set     = rsp_st.stop_set;
  assign rsp_o.ack_on       = rsp_st.ack_on;
  assign rsp_o.ack_off      = rsp_st.ack_off;
  assign rsp_o.write_strobe = rsp_st.write_strobe;
  assign rsp_o.write_byte   = rsp_st.write_byte;
  assign rsp_o.read_strobe  = rsp_st.read_strobe;
  assign rsp_o.read_byte    = rsp_st.read_byte;
  assign rsp_o.finished     = rsp_st.finished;
  assign rsp_o.failed       = rsp_st.failed;
  assign rsp_o.irq_clear    = rsp_st.irq_clear;

endmodule
`default_nettype wire

>>> hw/rtl/i2c_seq_checker.sv
// Port-level checker for the sequencer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module i2c_seq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic                          start_set,
  input wire logic                          stop_set,
  input wire logic                          write_strobe,
  input wire logic [i2c_seq_pkg::ByteW-1:0] write_byte,
  input wire logic                          read_strobe,
  input wire logic [i2c_seq_pkg::ByteW-1:0] read_byte,
  input wire logic                          finished,
  input wire logic                          failed
);

  `ASSERT_CLK(a_hold, clk_i, rst_ni, rsp_valid && !rsp_ready |=> rsp_valid && $stable(write_byte) && $stable(read_byte) && $stable(finished) && $stable(failed), "result changed while stalled")
  `ASSERT_NEVER(a_fin_fail, clk_i, rst_ni, rsp_valid && finished && failed, "finished and failed together")
  `ASSERT_NEVER(a_start_stop, clk_i, rst_ni, rsp_valid && start_set && stop_set, "start and stop together")
  `ASSERT_NEVER(a_wbyte, clk_i, rst_ni, rsp_valid && !write_strobe && write_byte != '0, "write byte without strobe")
  `ASSERT_NEVER(a_rbyte, clk_i, rst_ni, rsp_valid && !read_strobe && read_byte != '0, "read byte without strobe")

endmodule

bind i2c_master_register_transfer_sequencer i2c_seq_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .start_set    (rsp_o.start_set),
  .stop_set     (rsp_o.stop_set),
  .write_strobe (rsp_o.write_strobe),
  .write_byte   (rsp_o.write_byte),
  .read_strobe  (rsp_o.read_strobe),
  .read_byte    (rsp_o.read_byte),
  .finished     (rsp_o.finished),
  .failed       (rsp_o.failed)
);
`default_nettype wire

>>> dv/i2c_master_register_transfer_sequencer_tb.sv
// Self-checking testbench for the I2C register transfer sequencer, predicting every engine command.
`timescale 1ns / 1ps
module i2c_master_register_transfer_sequencer_tb;

  localparam int unsigned ByteW   = i2c_seq_pkg::ByteW;
  localparam int unsigned LengthW = i2c_seq_pkg::LengthW;
  localparam int unsigned CfgIdxW = i2c_seq_pkg::CfgIdxW;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned Phases      = 4;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxTop    = 8'hFF;

  logic clk_i;
  logic rst_ni;

  i2c_seq_req_if req_if ();
  i2c_seq_rsp_if rsp_if ();
  i2c_seq_cfg_if cfg_if ();

  i2c_master_register_transfer_sequencer #(.COUNT_BITS(16)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  i2c_seq_pkg::mode_e xfer_mode;
  logic [LengthW-1:0] bytes_done;
  logic [LengthW-1:0] bytes_total;
  logic [ByteW-1:0]   reg_sel;
  logic [8:0]         polls;
  logic [ByteW-1:0]   slave_addr;
  logic [ByteW-1:0]   poll_limit;

  i2c_seq_pkg::rsp_t exp_cmds[$];
  int unsigned       errors;
  int unsigned       items_sent;
  bit                idle_on;
  bit                derailed;
  int unsigned       hold_req   = 0;
  int unsigned       hold_seen  = 0;
  int unsigned       hold_left  = 0;
  int unsigned       stall_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic i2c_seq_pkg::rsp_t with_byte(i2c_seq_pkg::rsp_t c, logic [ByteW-1:0] b);
    c.write_strobe = 1'b1;
    c.write_byte   = b;
    return c;
  endfunction

  function automatic i2c_seq_pkg::rsp_t aborted(i2c_seq_pkg::rsp_t c);
    c.stop_set  = 1'b1;
    c.irq_clear = 1'b1;
    c.failed    = 1'b1;
    xfer_mode   = i2c_seq_pkg::MODE_IDLE;
    return c;
  endfunction

  function automatic i2c_seq_pkg::rsp_t engine_cmds_for(i2c_seq_pkg::req_t r);
    i2c_seq_pkg::rsp_t c;
    c = '0;
    case (r.action)
      i2c_seq_pkg::ACT_BEGIN_WRITE, i2c_seq_pkg::ACT_BEGIN_READ: begin
        if (xfer_mode == i2c_seq_pkg::MODE_IDLE) begin
          if (r.action == i2c_seq_pkg::ACT_BEGIN_READ && r.length == '0) begin
            c.failed = 1'b1;
          end else begin
            xfer_mode   = (r.action == i2c_seq_pkg::ACT_BEGIN_WRITE) ?
                          i2c_seq_pkg::MODE_WRITE : i2c_seq_pkg::MODE_READ;
            bytes_done  = '0;
            bytes_total = r.length;
            reg_sel     = r.reg_addr;
            polls       = '0;
            c.start_set = 1'b1;
          end
        end
      end
      i2c_seq_pkg::ACT_EVENT: begin
        if (xfer_mode == i2c_seq_pkg::MODE_WRITE) begin
          polls       = '0;
          c.irq_clear = 1'b1;
          case (r.status)
            i2c_seq_pkg::ST_START: begin
              c.start_clear = 1'b1;
              c = with_byte(c, slave_addr);
            end
            i2c_seq_pkg::ST_SLA_W_ACK: c = with_byte(c, reg_sel);
            i2c_seq_pkg::ST_DATA_W_ACK: begin
              if (bytes_done >= bytes_total) begin
                c.stop_set = 1'b1;
                c.finished = 1'b1;
                xfer_mode  = i2c_seq_pkg::MODE_IDLE;
              end else begin
                c = with_byte(c, r.tx_byte);
                bytes_done = bytes_done + LengthW'(1);
              end
            end
            i2c_seq_pkg::ST_SLA_W_NACK, i2c_seq_pkg::ST_DATA_W_NACK,
            i2c_seq_pkg::ST_ARB_LOST: c = aborted(c);
            default: ;
          endcase
        end else if (xfer_mode == i2c_seq_pkg::MODE_READ) begin
          polls       = '0;
          c.irq_clear = 1'b1;
          case (r.status)
            i2c_seq_pkg::ST_START: begin
              c.start_clear = 1'b1;
              c = with_byte(c, slave_addr);
            end
            i2c_seq_pkg::ST_SLA_W_ACK:  c = with_byte(c, reg_sel);
            i2c_seq_pkg::ST_DATA_W_ACK: c.start_set = 1'b1;
            i2c_seq_pkg::ST_RESTART: begin
              c.start_clear = 1'b1;
              c = with_byte(c, slave_addr | i2c_seq_pkg::READ_BIT);
            end
            i2c_seq_pkg::ST_SLA_R_ACK: begin
              if (bytes_total > LengthW'(1)) c.ack_on = 1'b1;
              else c.ack_off = 1'b1;
            end
            i2c_seq_pkg::ST_DATA_R_ACK: begin
              c.read_strobe = 1'b1;
              c.read_byte   = r.rx_byte;
              bytes_done    = bytes_done + LengthW'(1);
              if (bytes_done >= bytes_total) begin
                c.stop_set = 1'b1;
                c.finished = 1'b1;
                xfer_mode  = i2c_seq_pkg::MODE_IDLE;
              end else if (({1'b0, bytes_done} + 17'd1) == {1'b0, bytes_total}) begin
                c.ack_off = 1'b1;
              end
            end
            i2c_seq_pkg::ST_DATA_R_NACK: begin
              c.read_strobe = 1'b1;
              c.read_byte   = r.rx_byte;
              bytes_done    = bytes_done + LengthW'(1);
              c.stop_set    = 1'b1;
              if (bytes_done == bytes_total) c.finished = 1'b1;
              else c.failed = 1'b1;
              xfer_mode = i2c_seq_pkg::MODE_IDLE;
            end
            default: c = aborted(c);
          endcase
        end
      end
      default: begin
        if (xfer_mode != i2c_seq_pkg::MODE_IDLE) begin
          polls = polls + 9'd1;
          if (polls > {1'b0, poll_limit}) begin
            c = aborted(c);
            polls = '0;
          end
        end
      end
    endcase
    return c;
  endfunction

  function automatic void check_field(string name, logic [ByteW-1:0] want,
                                      logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    i2c_seq_pkg::rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (exp_cmds.size() == 0) begin
        $error("result arrived with no request pending");
        errors++;
      end else begin
        want = exp_cmds.pop_front();
        check_field("start_set", ByteW'(want.start_set), ByteW'(rsp_if.start_set));
        check_field("start_clear", ByteW'(want.start_clear), ByteW'(rsp_if.start_clear));
        check_field("stop_set", ByteW'(want.stop_set), ByteW'(rsp_if.stop_set));
        check_field("ack_on", ByteW'(want.ack_on), ByteW'(rsp_if.ack_on));
        check_field("ack_off", ByteW'(want.ack_off), ByteW'(rsp_if.ack_off));
        check_field("write_strobe", ByteW'(want.write_strobe),
                    ByteW'(rsp_if.write_strobe));
        check_field("write_byte", want.write_byte, rsp_if.write_byte);
        check_field("read_strobe", ByteW'(want.read_strobe), ByteW'(rsp_if.read_strobe));
        check_field("read_byte", want.read_byte, rsp_if.read_byte);
        check_field("finished", ByteW'(want.finished), ByteW'(rsp_if.finished));
        check_field("failed", ByteW'(want.failed), ByteW'(rsp_if.failed));
        check_field("irq_clear", ByteW'(want.irq_clear), ByteW'(rsp_if.irq_clear));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_left = HoldCycles;
      hold_seen = hold_req;
    end
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_req(input i2c_seq_pkg::req_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= r.action;
    req_if.reg_addr <= r.reg_addr;
    req_if.length   <= r.length;
    req_if.status   <= r.status;
    req_if.rx_byte  <= r.rx_byte;
    req_if.tx_byte  <= r.tx_byte;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    exp_cmds.push_back(engine_cmds_for(r));
    items_sent++;
  endtask

  function automatic i2c_seq_pkg::req_t rand_req(i2c_seq_pkg::action_e a);
    i2c_seq_pkg::req_t r;
    r.action   = a;
    r.reg_addr = ByteW'($urandom);
    r.length   = LengthW'($urandom);
    r.status   = ByteW'($urandom);
    r.rx_byte  = ByteW'($urandom);
    r.tx_byte  = ByteW'($urandom);
    return r;
  endfunction

  task automatic begin_xfer(i2c_seq_pkg::action_e a, logic [ByteW-1:0] addr,
                            logic [LengthW-1:0] len);
    i2c_seq_pkg::req_t r;
    r          = rand_req(a);
    r.reg_addr = addr;
    r.length   = len;
    send_req(r);
  endtask

  task automatic engine_event(logic [ByteW-1:0] st);
    i2c_seq_pkg::req_t r;
    r        = rand_req(i2c_seq_pkg::ACT_EVENT);
    r.status = st;
    send_req(r);
  endtask

  task automatic idle_poll();
    send_req(rand_req(i2c_seq_pkg::ACT_POLL));
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val, bit more = 1'b0);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    if (idx == i2c_seq_pkg::CFG_SLAVE_ADDRESS) slave_addr = val;
    else if (idx == i2c_seq_pkg::CFG_TIMEOUT_LIMIT) poll_limit = val;
    if (!more) cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    req_if.valid <= 1'b0;
    while (exp_cmds.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (exp_cmds.size() != 0) begin
      $error("%0d results still outstanding", exp_cmds.size());
      errors++;
      exp_cmds.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] stray_status();
    logic [ByteW-1:0] picks [6];
    picks = '{i2c_seq_pkg::ST_SLA_W_NACK, i2c_seq_pkg::ST_DATA_W_NACK,
              i2c_seq_pkg::ST_ARB_LOST, i2c_seq_pkg::ST_SLA_R_NACK,
              i2c_seq_pkg::ST_DATA_R_NACK, i2c_seq_pkg::ST_RESTART};
    derailed = 1'b1;
    if ($urandom_range(0, 3) == 0) return ByteW'($urandom);
    return picks[$urandom_range(0, 5)];
  endfunction

  task automatic maybe_polls();
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) idle_poll();
  endtask

  task automatic recover();
    if (derailed) begin
      engine_event(i2c_seq_pkg::ST_ARB_LOST);
      derailed = 1'b0;
    end
  endtask

  task automatic write_flow(logic [LengthW-1:0] len);
    recover();
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, ByteW'($urandom), len);
    maybe_polls();
    engine_event(i2c_seq_pkg::ST_START);
    maybe_polls();
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    for (int i = 0; i <= int'(len); i++) begin
      maybe_polls();
      if ($urandom_range(0, 49) == 0) engine_event(stray_status());
      else engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    end
  endtask

  task automatic read_flow(logic [LengthW-1:0] len);
    recover();
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, ByteW'($urandom), len);
    engine_event(i2c_seq_pkg::ST_START);
    maybe_polls();
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    maybe_polls();
    engine_event(i2c_seq_pkg::ST_RESTART);
    engine_event(i2c_seq_pkg::ST_SLA_R_ACK);
    for (int i = 1; i <= int'(len); i++) begin
      maybe_polls();
      if ($urandom_range(0, 49) == 0) engine_event(stray_status());
      else if (i == int'(len)) engine_event($urandom_range(0, 3) == 0 ?
                                            i2c_seq_pkg::ST_DATA_R_ACK :
                                            i2c_seq_pkg::ST_DATA_R_NACK);
      else engine_event(i2c_seq_pkg::ST_DATA_R_ACK);
    end
  endtask

  function automatic logic [LengthW-1:0] short_len();
    if ($urandom_range(0, 9) == 0) return LengthW'($urandom_range(9, 40));
    return LengthW'($urandom_range(0, 8));
  endfunction

  task automatic test_reset_defaults();
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, 8'h00, 16'd1);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'hFF, 16'd1);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    engine_event(i2c_seq_pkg::ST_RESTART);
    engine_event(i2c_seq_pkg::ST_SLA_R_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_R_NACK);
    settle();
  endtask

  task automatic test_special_cases();
    idle_poll();
    engine_event(i2c_seq_pkg::ST_START);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'h12, 16'd0);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, 8'h34, 16'd0);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, 8'hA5, 16'hFFFF);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'h5A, 16'd3);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_SLA_R_NACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    engine_event(i2c_seq_pkg::ST_SLA_W_NACK);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, 8'h01, 16'd2);
    engine_event(i2c_seq_pkg::ST_DATA_W_NACK);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, 8'h02, 16'd2);
    engine_event(i2c_seq_pkg::ST_ARB_LOST);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'h80, 16'd3);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    engine_event(i2c_seq_pkg::ST_RESTART);
    engine_event(i2c_seq_pkg::ST_SLA_R_ACK);
    repeat (3) engine_event(i2c_seq_pkg::ST_DATA_R_ACK);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'h7F, 16'd4);
    engine_event(i2c_seq_pkg::ST_SLA_R_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_R_NACK);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'hC3, 16'd2);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_DATA_W_NACK);
    settle();
  endtask

  task automatic test_register_writes();
    cfg_write(i2c_seq_pkg::CFG_SLAVE_ADDRESS, 8'h00, 1'b1);
    cfg_write(CfgIdxUnused, 8'hFF, 1'b1);
    cfg_write(CfgIdxTop, 8'h55);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'h10, 16'd2);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    engine_event(i2c_seq_pkg::ST_RESTART);
    engine_event(i2c_seq_pkg::ST_ARB_LOST);
    settle();
    cfg_write(i2c_seq_pkg::CFG_SLAVE_ADDRESS, 8'hFF);
    read_flow(16'd2);
    settle();
  endtask

  task automatic test_timeouts();
    cfg_write(i2c_seq_pkg::CFG_SLAVE_ADDRESS, 8'hFE, 1'b1);
    cfg_write(i2c_seq_pkg::CFG_TIMEOUT_LIMIT, 8'd3);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_WRITE, 8'h3C, 16'd2);
    repeat (3) idle_poll();
    engine_event(i2c_seq_pkg::ST_START);
    repeat (4) idle_poll();
    settle();
    cfg_write(i2c_seq_pkg::CFG_TIMEOUT_LIMIT, 8'd0);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'h5A, 16'd1);
    idle_poll();
    settle();
    cfg_write(i2c_seq_pkg::CFG_TIMEOUT_LIMIT, 8'hFF);
    begin_xfer(i2c_seq_pkg::ACT_BEGIN_READ, 8'hE7, 16'd2);
    engine_event(i2c_seq_pkg::ST_START);
    engine_event(i2c_seq_pkg::ST_SLA_W_ACK);
    engine_event(i2c_seq_pkg::ST_DATA_W_ACK);
    engine_event(i2c_seq_pkg::ST_RESTART);
    repeat (255) idle_poll();
    engine_event(i2c_seq_pkg::ST_SLA_R_ACK);
    repeat (256) idle_poll();
    settle();
  endtask

  task automatic test_backpressure();
    cfg_write(i2c_seq_pkg::CFG_TIMEOUT_LIMIT, 8'd1);
    hold_req++;
    repeat (4) write_flow(16'd8);
    read_flow(16'd10);
    settle();
  endtask

  task automatic test_random_transfers();
    int unsigned base;
    base = items_sent;
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph == Phases - 1) idle_on = 1'b0;
      cfg_write(i2c_seq_pkg::CFG_SLAVE_ADDRESS, ByteW'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(i2c_seq_pkg::CFG_TIMEOUT_LIMIT, ByteW'($urandom_range(1, 4)));
      end else begin
        cfg_write(i2c_seq_pkg::CFG_TIMEOUT_LIMIT, ByteW'($urandom_range(5, 255)));
      end
      while (items_sent < base + (ph + 1) * RandomItems / Phases) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 4)) begin
              send_req(rand_req(i2c_seq_pkg::action_e'($urandom_range(0, 3))));
            end
            derailed = 1'b1;
          end
          1, 2, 3, 4: write_flow(short_len());
          default: read_flow(short_len());
        endcase
      end
      recover();
      settle();
    end
  endtask

  task automatic finish_run();
    settle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  endtask

  initial begin : run
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = i2c_seq_pkg::ACT_POLL;
    req_if.reg_addr = '0;
    req_if.length   = '0;
    req_if.status   = '0;
    req_if.rx_byte  = '0;
    req_if.tx_byte  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    idle_on         = 1'b1;
    derailed        = 1'b0;
    errors          = 0;
    items_sent      = 0;
    xfer_mode       = i2c_seq_pkg::MODE_IDLE;
    bytes_done      = '0;
    bytes_total     = '0;
    reg_sel         = '0;
    polls           = '0;
    slave_addr      = i2c_seq_pkg::SLAVE_ADDRESS_RST;
    poll_limit      = i2c_seq_pkg::TIMEOUT_LIMIT_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_cases();
    test_register_writes();
    test_timeouts();
    test_backpressure();
    test_random_transfers();
    finish_run();
  end

  initial begin : watchdog
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/i2c_seq_pkg.sv
hw/rtl/i2c_seq_if.sv
hw/rtl/i2c_seq_in_reg.sv
hw/rtl/i2c_seq_core.sv
hw/rtl/i2c_seq_out_reg.sv
hw/rtl/i2c_master_register_transfer_sequencer.sv
hw/rtl/i2c_seq_checker.sv
dv/i2c_master_register_transfer_sequencer_tb.sv
